// ----- design/pet_pkg.sv -----
// Package for the priority task and timed event scheduler.
// Holds sizes, item structs, action/mode/state codes and the event-cell types.
// No dependencies.
package pet_pkg;

  localparam int TASK_SLOTS    = 16;
  localparam int EVENT_ENTRIES = 32;
  localparam int TIME_BITS     = 32;
  localparam int TAG_BITS      = 16;
  localparam int SLOT_W        = $clog2(TASK_SLOTS);
  localparam int SPAN_W        = 8;

  // action codes (6 and 7 mean nothing)
  localparam logic [2:0] ACT_ADD      = 3'd0;
  localparam logic [2:0] ACT_TRIGGER  = 3'd1;
  localparam logic [2:0] ACT_DELETE   = 3'd2;
  localparam logic [2:0] ACT_TICK     = 3'd3;
  localparam logic [2:0] ACT_DISPATCH = 3'd4;
  localparam logic [2:0] ACT_COMPLETE = 3'd5;

  // task modes
  localparam logic [1:0] MODE_SINGLE   = 2'd0;
  localparam logic [1:0] MODE_PERIODIC = 2'd1;
  localparam logic [1:0] MODE_ALWAYS   = 2'd2;
  localparam logic [1:0] MODE_EVENT    = 2'd3;

  // task states
  localparam logic [1:0] TS_IDLE  = 2'd0;
  localparam logic [1:0] TS_WAIT  = 2'd1;
  localparam logic [1:0] TS_READY = 2'd2;
  localparam logic [1:0] TS_BLOCK = 2'd3;

  typedef struct packed {
    logic [2:0]           action;
    logic [3:0]           task_slot;
    logic [1:0]           task_mode;
    logic [7:0]           task_priority;
    logic [TIME_BITS-1:0] task_period;
    logic [TIME_BITS-1:0] time_offset;
    logic [TAG_BITS-1:0]  event_tag;
  } pet_in_t;

  typedef struct packed {
    logic                 accepted;
    logic                 dispatch_valid;
    logic [3:0]           dispatch_slot;
    logic [TAG_BITS-1:0]  dispatch_tag;
    logic [TIME_BITS-1:0] time_now;
  } pet_out_t;

  // one task slot
  typedef struct packed {
    logic [1:0]           mode;
    logic [7:0]           prio;
    logic [TIME_BITS-1:0] period;
    logic [TIME_BITS-1:0] last_run;
    logic [1:0]           st;
  } pet_slot_t;

  // one pending event held in a cell
  typedef struct packed {
    logic                 vld;
    logic [SLOT_W-1:0]    owner;
    logic [TIME_BITS-1:0] tim;
    logic [TAG_BITS-1:0]  tag;
  } pet_entry_t;

  // operation broadcast to all event cells
  typedef enum logic [2:0] {
    COP_HOLD,
    COP_INSERT,
    COP_MARK_SLOT,
    COP_MARK_DEL,
    COP_MARK_FIRST,
    COP_SHIFT
  } pet_cop_t;

  typedef struct packed {
    pet_cop_t             op;
    logic [SLOT_W-1:0]    key_slot;
    logic [TIME_BITS-1:0] key_time;
    logic [TAG_BITS-1:0]  key_tag;
    logic [TIME_BITS-1:0] now;
  } pet_ctl_t;

endpackage

// ----- design/priority_task_event_scheduler.sv -----
// Priority task scheduler with a timed event queue: top level.
// Uses pet_pkg and pet_chain (row of pet_cell).
//
// Usage:
//  - Input: drive in_item and raise start; the item is taken at a clock edge
//    with start high and busy low. busy stays high while the item is worked.
//  - Result: out_valid pulses for one cycle with out_item; it cannot be held.
//  - Config: cfg_we with cfg_data writes tick_span; write only while idle.
// Sequence per action (from S_EXEC to out_valid):
//  - trigger, complete, unknown action, delete on a non-event slot: S_EXEC only.
//  - add, other delete: S_SHIFT until no marked event is left in the queue.
//  - tick: S_TSCAN, one slot of the task table checked per cycle.
//  - dispatch: S_DSCAN over all slots, then S_DPICK if a ready task is
//    found; an event task goes on to S_DPOP and then S_SHIFT.
// The task-table scan uses the single read port of the table;
// queue compaction removes one event per cycle.
// A new item may be started in the cycle out_valid is shown.
// Reset: time 0, tick_span 1, all slots unused, event queue empty.
module priority_task_event_scheduler import pet_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pet_in_t           in_item,
  output logic              out_valid,
  output pet_out_t          out_item,
  input  logic              cfg_we,
  input  logic [SPAN_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_TSCAN, S_DSCAN, S_DPICK, S_DPOP, S_SHIFT
  } state_t;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS-1);

  state_t                state_r, state_nxt;
  pet_in_t               in_r, in_nxt;
  logic [TIME_BITS-1:0]  sum_r, sum_nxt;
  logic [TIME_BITS-1:0]  now_r, now_nxt;
  logic [SPAN_W-1:0]     span_r;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;
  logic [SLOT_W-1:0]     best_r, best_nxt;
  logic [7:0]            maxp_r, maxp_nxt;
  logic                  found_r, found_nxt;
  logic                  acc_r, acc_nxt;
  logic                  dv_r, dv_nxt;
  logic [3:0]            ds_r, ds_nxt;
  logic [TAG_BITS-1:0]   dt_r, dt_nxt;
  logic                  outv_r, outv_nxt;
  logic [TASK_SLOTS-1:0] used_r, used_nxt;

  pet_slot_t             slot_tbl_r [TASK_SLOTS];
  pet_slot_t             cur, tbl_wd;
  logic                  tbl_we, cur_used;
  logic [TIME_BITS-1:0]  due_time;

  pet_ctl_t              ctl;
  logic                  ev_full, ev_any_kill;
  logic [TAG_BITS-1:0]   ev_first_tag;
  logic [TASK_SLOTS-1:0] ev_due;

  pet_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .full     (ev_full),
    .any_kill (ev_any_kill),
    .first_tag(ev_first_tag),
    .due_vec  (ev_due)
  );

  // single read port of the task table
  assign cur      = slot_tbl_r[idx_r];
  assign cur_used = used_r[idx_r];
  assign due_time = cur.last_run + cur.period;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    in_nxt    = in_r;
    sum_nxt   = sum_r;
    now_nxt   = now_r;
    idx_nxt   = idx_r;
    best_nxt  = best_r;
    maxp_nxt  = maxp_r;
    found_nxt = found_r;
    acc_nxt   = acc_r;
    dv_nxt    = dv_r;
    ds_nxt    = ds_r;
    dt_nxt    = dt_r;
    outv_nxt  = 1'b0;
    used_nxt  = used_r;
    tbl_we    = 1'b0;
    tbl_wd    = cur;
    ctl.op       = COP_HOLD;
    ctl.key_slot = idx_r;
    ctl.key_time = sum_r;
    ctl.key_tag  = in_r.event_tag;
    ctl.now      = now_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          in_nxt    = in_item;
          sum_nxt   = now_r + in_item.time_offset;
          idx_nxt   = in_item.task_slot;
          acc_nxt   = 1'b0;
          dv_nxt    = 1'b0;
          ds_nxt    = '0;
          dt_nxt    = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (in_r.action)
          ACT_ADD: begin
            tbl_we          = 1'b1;
            tbl_wd.mode     = in_r.task_mode;
            tbl_wd.prio     = in_r.task_priority;
            tbl_wd.period   = in_r.task_period;
            tbl_wd.last_run = now_r;
            tbl_wd.st       = (in_r.task_mode == MODE_PERIODIC) ? TS_WAIT :
                              (in_r.task_mode == MODE_EVENT) ? TS_BLOCK : TS_READY;
            used_nxt[idx_r] = 1'b1;
            acc_nxt         = 1'b1;
            ctl.op          = COP_MARK_SLOT;
            state_nxt       = S_SHIFT;
          end
          ACT_TRIGGER: begin
            if (cur_used && cur.mode == MODE_EVENT && !ev_full) begin
              ctl.op  = COP_INSERT;
              acc_nxt = 1'b1;
            end
            outv_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
          ACT_DELETE: begin
            acc_nxt = 1'b1;
            if (cur_used && cur.mode == MODE_EVENT) begin
              ctl.op    = COP_MARK_DEL;
              state_nxt = S_SHIFT;
            end else begin
              outv_nxt  = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          ACT_TICK: begin
            now_nxt   = now_r + TIME_BITS'(span_r);
            idx_nxt   = '0;
            acc_nxt   = 1'b1;
            state_nxt = S_TSCAN;
          end
          ACT_DISPATCH: begin
            idx_nxt   = '0;
            best_nxt  = '0;
            maxp_nxt  = '0;
            found_nxt = 1'b0;
            acc_nxt   = 1'b1;
            state_nxt = S_DSCAN;
          end
          ACT_COMPLETE: begin
            if (cur_used) begin
              tbl_we          = 1'b1;
              tbl_wd.last_run = sum_r;
              case (cur.mode)
                MODE_SINGLE:   tbl_wd.st = TS_IDLE;
                MODE_PERIODIC: tbl_wd.st = TS_WAIT;
                MODE_ALWAYS:   tbl_wd.st = TS_READY;
                default:       tbl_wd.st = TS_BLOCK;
              endcase
              acc_nxt = 1'b1;
            end
            outv_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
          default: begin
            outv_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_TSCAN: begin
        // mark due periodic and event tasks ready
        if (cur_used) begin
          if (cur.mode == MODE_PERIODIC && cur.st == TS_WAIT && now_r >= due_time) begin
            tbl_we    = 1'b1;
            tbl_wd.st = TS_READY;
          end
          if (cur.mode == MODE_EVENT && ev_due[idx_r]) begin
            tbl_we    = 1'b1;
            tbl_wd.st = TS_READY;
          end
        end
        if (idx_r == LAST_SLOT) begin
          outv_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DSCAN: begin
        // highest priority wins, lowest slot on ties
        if (cur_used && cur.st == TS_READY && cur.prio > maxp_r) begin
          maxp_nxt  = cur.prio;
          best_nxt  = idx_r;
          found_nxt = 1'b1;
        end
        if (idx_r == LAST_SLOT) begin
          if (found_nxt) begin
            idx_nxt   = best_nxt;
            state_nxt = S_DPICK;
          end else begin
            outv_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DPICK: begin
        dv_nxt = 1'b1;
        ds_nxt = 4'(idx_r);
        if (cur.mode == MODE_EVENT) begin
          state_nxt = S_DPOP;
        end else begin
          outv_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DPOP: begin
        ctl.op    = COP_MARK_FIRST;
        dt_nxt    = ev_first_tag;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        // close one gap per cycle until no marked event is left
        if (ev_any_kill) begin
          ctl.op = COP_SHIFT;
        end else begin
          outv_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      outv_r  <= 1'b0;
      used_r  <= '0;
      now_r   <= '0;
      span_r  <= SPAN_W'(1);
    end else begin
      state_r <= state_nxt;
      outv_r  <= outv_nxt;
      used_r  <= used_nxt;
      now_r   <= now_nxt;
      if (cfg_we) begin
        span_r <= cfg_data;
      end
    end
    in_r    <= in_nxt;
    sum_r   <= sum_nxt;
    idx_r   <= idx_nxt;
    best_r  <= best_nxt;
    maxp_r  <= maxp_nxt;
    found_r <= found_nxt;
    acc_r   <= acc_nxt;
    dv_r    <= dv_nxt;
    ds_r    <= ds_nxt;
    dt_r    <= dt_nxt;
  end

  // task table, written at the read address
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      slot_tbl_r[idx_r] <= tbl_wd;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = outv_r;
  assign out_item  = '{accepted: acc_r, dispatch_valid: dv_r, dispatch_slot: ds_r,
                       dispatch_tag: dt_r, time_now: now_r};

endmodule

// ----- design/pet_cell.sv -----
// One cell of the sorted event queue: holds one event and a kill mark.
// Talks only to its two neighbors and the broadcast control. Uses pet_pkg.
module pet_cell import pet_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pet_ctl_t              ctl,
  input  pet_entry_t            left_ent,
  input  pet_entry_t            right_ent,
  input  logic                  right_kill,
  input  logic                  prev_le,
  input  logic                  pk_in,
  input  logic                  seen_in,
  input  logic [TAG_BITS-1:0]   tag_in,
  input  logic [TASK_SLOTS-1:0] due_in,
  output pet_entry_t            ent_out,
  output logic                  kill_out,
  output logic                  le_out,
  output logic                  pk_out,
  output logic                  seen_out,
  output logic [TAG_BITS-1:0]   tag_out,
  output logic [TASK_SLOTS-1:0] due_out
);

  pet_entry_t ent_r, ent_nxt;
  logic       kill_r, kill_nxt;
  logic       match_slot;

  // local compares
  assign le_out     = ent_r.vld && (ent_r.tim <= ctl.key_time);
  assign match_slot = ent_r.vld && (ent_r.owner == ctl.key_slot);

  // chains passed to the right neighbor
  assign pk_out   = pk_in | kill_r;
  assign seen_out = seen_in | match_slot;
  assign tag_out  = seen_in ? tag_in : (match_slot ? ent_r.tag : '0);
  assign due_out  = due_in |
                    ((ent_r.vld && (ent_r.tim <= ctl.now)) ?
                     ({{(TASK_SLOTS-1){1'b0}}, 1'b1} << ent_r.owner) : '0);

  assign ent_out  = ent_r;
  assign kill_out = kill_r;

  // next cell contents
  always_comb begin
    ent_nxt  = ent_r;
    kill_nxt = kill_r;
    case (ctl.op)
      COP_INSERT: begin
        if (!le_out) begin
          if (prev_le) begin
            ent_nxt = '{vld: 1'b1, owner: ctl.key_slot, tim: ctl.key_time, tag: ctl.key_tag};
          end else begin
            ent_nxt = left_ent;
          end
        end
      end
      COP_MARK_SLOT:  kill_nxt = match_slot;
      COP_MARK_DEL:   kill_nxt = match_slot && (ent_r.tag == ctl.key_tag) && le_out;
      COP_MARK_FIRST: kill_nxt = match_slot && !seen_in;
      COP_SHIFT: begin
        if (pk_out) begin
          ent_nxt  = right_ent;
          kill_nxt = right_kill;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
      kill_r    <= 1'b0;
    end else begin
      ent_r.vld <= ent_nxt.vld;
      kill_r    <= kill_nxt;
    end
    // event payload, no reset
    ent_r.owner <= ent_nxt.owner;
    ent_r.tim   <= ent_nxt.tim;
    ent_r.tag   <= ent_nxt.tag;
  end

endmodule

// ----- design/pet_chain.sv -----
// Row of event cells forming a compacted queue sorted by trigger time.
// Depends on pet_pkg and pet_cell.
module pet_chain import pet_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pet_ctl_t              ctl,
  output logic                  full,
  output logic                  any_kill,
  output logic [TAG_BITS-1:0]   first_tag,
  output logic [TASK_SLOTS-1:0] due_vec
);

  pet_entry_t            ent_w  [EVENT_ENTRIES];
  logic                  kill_w [EVENT_ENTRIES];
  logic                  le_w   [EVENT_ENTRIES];
  logic                  pk_w   [EVENT_ENTRIES];
  logic                  seen_w [EVENT_ENTRIES];
  logic [TAG_BITS-1:0]   tag_w  [EVENT_ENTRIES];
  logic [TASK_SLOTS-1:0] due_w  [EVENT_ENTRIES];

  for (genvar k = 0; k < EVENT_ENTRIES; k++) begin : g_cell
    pet_entry_t            l_ent, r_ent;
    logic                  r_kill, p_le, p_pk, p_seen;
    logic [TAG_BITS-1:0]   p_tag;
    logic [TASK_SLOTS-1:0] p_due;

    if (k == 0) begin : g_head
      assign l_ent  = '0;
      assign p_le   = 1'b1;
      assign p_pk   = 1'b0;
      assign p_seen = 1'b0;
      assign p_tag  = '0;
      assign p_due  = '0;
    end else begin : g_mid
      assign l_ent  = ent_w[k-1];
      assign p_le   = le_w[k-1];
      assign p_pk   = pk_w[k-1];
      assign p_seen = seen_w[k-1];
      assign p_tag  = tag_w[k-1];
      assign p_due  = due_w[k-1];
    end

    if (k == EVENT_ENTRIES-1) begin : g_tail
      assign r_ent  = '0;
      assign r_kill = 1'b0;
    end else begin : g_body
      assign r_ent  = ent_w[k+1];
      assign r_kill = kill_w[k+1];
    end

    pet_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .left_ent  (l_ent),
      .right_ent (r_ent),
      .right_kill(r_kill),
      .prev_le   (p_le),
      .pk_in     (p_pk),
      .seen_in   (p_seen),
      .tag_in    (p_tag),
      .due_in    (p_due),
      .ent_out   (ent_w[k]),
      .kill_out  (kill_w[k]),
      .le_out    (le_w[k]),
      .pk_out    (pk_w[k]),
      .seen_out  (seen_w[k]),
      .tag_out   (tag_w[k]),
      .due_out   (due_w[k])
    );
  end

  // chain ends
  assign full      = ent_w[EVENT_ENTRIES-1].vld;
  assign any_kill  = pk_w[EVENT_ENTRIES-1];
  assign first_tag = tag_w[EVENT_ENTRIES-1];
  assign due_vec   = due_w[EVENT_ENTRIES-1];

endmodule

// ----- design/pet_checker.sv -----
// Port-level checks for priority_task_event_scheduler, bound to the top level.
// Depends on pet_pkg.
module pet_checker import pet_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input pet_out_t          out_item
);

  // a taken item makes the block busy
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("item taken but block not busy");

  // result strobe lasts one cycle
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  // the block leaves busy exactly with a result
  a_fell_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid) else $error("busy dropped without a result");

  // no result while still working
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");

  // without a dispatch the slot and tag read zero
  a_no_disp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.dispatch_valid |->
      out_item.dispatch_slot == '0 && out_item.dispatch_tag == '0)
    else $error("dispatch fields set without a dispatch");

endmodule

bind priority_task_event_scheduler pet_checker u_pet_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_item (out_item)
);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench for priority_task_event_scheduler: directed and random items,
// each result checked against an in-bench model of the scheduler.
// Depends on pet_pkg and the scheduler RTL.
module tb;
  import pet_pkg::*;

  localparam int IN_W = $bits(pet_in_t);

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  pet_in_t           in_item;
  logic              out_valid;
  pet_out_t          out_item;
  logic              cfg_we;
  logic [SPAN_W-1:0] cfg_data;

  priority_task_event_scheduler uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // scheduler model state
  logic [TIME_BITS-1:0] m_now;
  logic [SPAN_W-1:0]    m_span;
  logic                 m_used   [TASK_SLOTS];
  logic [1:0]           m_mode   [TASK_SLOTS];
  logic [7:0]           m_prio   [TASK_SLOTS];
  logic [TIME_BITS-1:0] m_period [TASK_SLOTS];
  logic [TIME_BITS-1:0] m_last   [TASK_SLOTS];
  logic [1:0]           m_state  [TASK_SLOTS];
  logic [3:0]           q_owner  [EVENT_ENTRIES];
  logic [TIME_BITS-1:0] q_time   [EVENT_ENTRIES];
  logic [TAG_BITS-1:0]  q_tag    [EVENT_ENTRIES];
  int                   q_count;

  pet_out_t pending_results[$];
  int errors;
  int items_sent;
  int dispatch_hits;
  int refused_triggers;
  bit no_idle;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  // drop one event and close the gap
  function automatic void queue_remove(int pos);
    for (int k = pos; k + 1 < q_count; k++) begin
      q_owner[k] = q_owner[k+1];
      q_time[k]  = q_time[k+1];
      q_tag[k]   = q_tag[k+1];
    end
    q_count--;
  endfunction

  function automatic int queue_first(int slot);
    for (int k = 0; k < q_count; k++)
      if (q_owner[k] == slot) return k;
    return -1;
  endfunction

  // expected result of one item; updates model state
  function automatic pet_out_t sched_predict(pet_in_t it);
    pet_out_t r;
    int s;
    int k;
    int e;
    int best;
    int maxp;
    logic [TIME_BITS-1:0] t;
    s = int'(it.task_slot);
    r = '0;
    case (it.action)
      ACT_ADD: begin
        m_used[s] = 1'b1;
        m_mode[s] = it.task_mode;
        m_prio[s] = it.task_priority;
        m_period[s] = it.task_period;
        m_last[s] = m_now;
        m_state[s] = (it.task_mode == MODE_PERIODIC) ? TS_WAIT :
                     (it.task_mode == MODE_EVENT) ? TS_BLOCK : TS_READY;
        k = 0;
        while (k < q_count) if (q_owner[k] == s) queue_remove(k); else k++;
        r.accepted = 1'b1;
      end
      ACT_TRIGGER: begin
        if (m_used[s] && m_mode[s] == MODE_EVENT && q_count < EVENT_ENTRIES) begin
          t = m_now + it.time_offset;
          e = 0;
          while (e < q_count && q_time[e] <= t) e++;
          for (k = q_count; k > e; k--) begin
            q_owner[k] = q_owner[k-1];
            q_time[k]  = q_time[k-1];
            q_tag[k]   = q_tag[k-1];
          end
          q_owner[e] = 4'(s);
          q_time[e]  = t;
          q_tag[e]   = it.event_tag;
          q_count++;
          r.accepted = 1'b1;
        end else begin
          refused_triggers++;
        end
      end
      ACT_DELETE: begin
        if (m_used[s] && m_mode[s] == MODE_EVENT) begin
          t = m_now + it.time_offset;
          k = 0;
          while (k < q_count)
            if (q_owner[k] == s && q_tag[k] == it.event_tag && q_time[k] <= t)
              queue_remove(k);
            else k++;
        end
        r.accepted = 1'b1;
      end
      ACT_TICK: begin
        m_now = m_now + m_span;
        for (k = 0; k < TASK_SLOTS; k++) begin
          if (m_used[k]) begin
            if (m_mode[k] == MODE_PERIODIC && m_state[k] == TS_WAIT &&
                m_now >= m_last[k] + m_period[k])
              m_state[k] = TS_READY;
            if (m_mode[k] == MODE_EVENT) begin
              e = queue_first(k);
              if (e >= 0 && m_now >= q_time[e]) m_state[k] = TS_READY;
            end
          end
        end
        r.accepted = 1'b1;
      end
      ACT_DISPATCH: begin
        best = -1;
        maxp = 0;
        for (k = 0; k < TASK_SLOTS; k++)
          if (m_used[k] && m_state[k] == TS_READY && m_prio[k] > maxp) begin
            maxp = m_prio[k];
            best = k;
          end
        if (best >= 0) begin
          r.dispatch_valid = 1'b1;
          r.dispatch_slot = 4'(best);
          dispatch_hits++;
          if (m_mode[best] == MODE_EVENT) begin
            e = queue_first(best);
            if (e >= 0) begin
              r.dispatch_tag = q_tag[e];
              queue_remove(e);
            end
          end
        end
        r.accepted = 1'b1;
      end
      ACT_COMPLETE: begin
        if (m_used[s]) begin
          m_last[s] = m_now + it.time_offset;
          case (m_mode[s])
            MODE_SINGLE:   m_state[s] = TS_IDLE;
            MODE_PERIODIC: m_state[s] = TS_WAIT;
            MODE_ALWAYS:   m_state[s] = TS_READY;
            default:       m_state[s] = TS_BLOCK;
          endcase
          r.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    r.time_now = m_now;
    return r;
  endfunction

  // send one item, predict at acceptance, maybe idle afterwards
  task automatic send_item(pet_in_t it);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(sched_predict(it));
    items_sent++;
    if (!no_idle && $urandom_range(99) < 28) begin
      start <= 1'b0;
      in_item <= IN_W'({$urandom, $urandom, $urandom, $urandom});
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_span(logic [SPAN_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_span = v;
  endtask

  function automatic pet_in_t make_item(logic [2:0] act, int slot, logic [1:0] mode,
                                        logic [7:0] prio, logic [31:0] period,
                                        logic [31:0] offs, logic [15:0] tag);
    pet_in_t it;
    it.action = act;
    it.task_slot = 4'(slot);
    it.task_mode = mode;
    it.task_priority = prio;
    it.task_period = period;
    it.time_offset = offs;
    it.event_tag = tag;
    return it;
  endfunction

  // random item, mostly meaningful scheduler traffic
  function automatic pet_in_t random_item();
    pet_in_t it;
    int w;
    it = IN_W'({$urandom, $urandom, $urandom, $urandom});
    w = $urandom_range(99);
    if (w < 10)      it.action = ACT_ADD;
    else if (w < 36) it.action = ACT_TRIGGER;
    else if (w < 44) it.action = ACT_DELETE;
    else if (w < 64) it.action = ACT_TICK;
    else if (w < 84) it.action = ACT_DISPATCH;
    else if (w < 97) it.action = ACT_COMPLETE;
    else             it.action = 3'($urandom_range(6, 7));
    if ($urandom_range(3) != 0) begin
      it.task_period = $urandom_range(0, 40);
      it.time_offset = $urandom_range(0, 60);
      it.event_tag = TAG_BITS'($urandom_range(0, 3));
    end
    return it;
  endfunction

  // directed: each mode, priority ties and extremes, refusals, unknown codes
  task automatic test_directed;
    send_item(make_item(ACT_COMPLETE, 4, MODE_SINGLE, 8'd0, '0, 32'd5, '0));
    send_item(make_item(ACT_TRIGGER, 4, MODE_SINGLE, 8'd0, '0, 32'd5, 16'hFFFF));
    send_item(make_item(ACT_DISPATCH, 0, MODE_SINGLE, 8'd0, '0, '0, '0));
    send_item(make_item(ACT_ADD, 0, MODE_SINGLE, 8'd0, '0, '0, '0));
    send_item(make_item(ACT_ADD, 15, MODE_ALWAYS, 8'd255, 32'hFFFFFFFF, '0, '0));
    send_item(make_item(ACT_ADD, 3, MODE_ALWAYS, 8'd255, '0, '0, '0));
    send_item(make_item(ACT_ADD, 7, MODE_PERIODIC, 8'd100, 32'd3, '0, '0));
    send_item(make_item(ACT_ADD, 9, MODE_EVENT, 8'd200, '0, '0, '0));
    send_item(make_item(ACT_TRIGGER, 7, MODE_SINGLE, 8'd0, '0, 32'd1, 16'h1));
    send_item(make_item(ACT_TRIGGER, 9, MODE_SINGLE, 8'd0, '0, 32'd2, 16'hAAAA));
    send_item(make_item(ACT_TRIGGER, 9, MODE_SINGLE, 8'd0, '0, 32'd2, 16'h5555));
    send_item(make_item(ACT_TRIGGER, 9, MODE_SINGLE, 8'd0, '0, 32'hFFFFFFFF, 16'h1234));
    send_item(make_item(ACT_DELETE, 9, MODE_SINGLE, 8'd0, '0, 32'd2, 16'h5555));
    send_item(make_item(ACT_DISPATCH, 0, MODE_SINGLE, 8'd0, '0, '0, '0));
    send_item(make_item(ACT_COMPLETE, 3, MODE_SINGLE, 8'd0, '0, '0, '0));
    send_item(make_item(ACT_TICK, 0, MODE_SINGLE, 8'd0, '0, '0, '0));
    send_item(make_item(ACT_TICK, 0, MODE_SINGLE, 8'd0, '0, '0, '0));
    send_item(make_item(ACT_TICK, 0, MODE_SINGLE, 8'd0, '0, '0, '0));
    send_item(make_item(ACT_DISPATCH, 0, MODE_SINGLE, 8'd0, '0, '0, '0));
    send_item(make_item(ACT_COMPLETE, 9, MODE_SINGLE, 8'd0, '0, 32'hFFFFFFFF, '0));
    send_item(make_item(ACT_COMPLETE, 15, MODE_SINGLE, 8'd0, '0, '0, '0));
    send_item(make_item(ACT_DISPATCH, 0, MODE_SINGLE, 8'd0, '0, '0, '0));
    send_item(make_item(3'd6, 1, MODE_EVENT, 8'd9, '1, '1, '1));
    send_item(make_item(3'd7, 1, MODE_EVENT, 8'd9, '1, '1, '1));
    send_item(make_item(ACT_ADD, 9, MODE_SINGLE, 8'd1, '0, '0, '0));
  endtask

  // fill the event store past its size so triggers get refused
  task automatic test_store_full;
    send_item(make_item(ACT_ADD, 2, MODE_EVENT, 8'd50, '0, '0, '0));
    for (int i = 0; i < EVENT_ENTRIES + 4; i++)
      send_item(make_item(ACT_TRIGGER, 2, MODE_SINGLE, 8'd0, '0,
                          $urandom_range(0, 8), 16'($urandom)));
    for (int i = 0; i < 6; i++) begin
      send_item(make_item(ACT_TICK, 0, MODE_SINGLE, 8'd0, '0, '0, '0));
      send_item(make_item(ACT_DISPATCH, 0, MODE_SINGLE, 8'd0, '0, '0, '0));
    end
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_item(random_item());
  endtask

  // result checker
  always @(posedge clk) begin
    pet_out_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", out_item);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_item.accepted !== exp_r.accepted ||
            out_item.dispatch_valid !== exp_r.dispatch_valid ||
            out_item.dispatch_slot !== exp_r.dispatch_slot ||
            out_item.dispatch_tag !== exp_r.dispatch_tag ||
            out_item.time_now !== exp_r.time_now) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %p, got %p", exp_r, out_item);
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    errors = 0;
    items_sent = 0;
    dispatch_hits = 0;
    refused_triggers = 0;
    no_idle = 1'b0;
    m_now = '0;
    m_span = SPAN_W'(1);
    q_count = 0;
    for (int k = 0; k < TASK_SLOTS; k++) m_used[k] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_store_full();
    test_random(300);
    write_span(8'd255);
    test_random(250);
    write_span(SPAN_W'($urandom_range(2, 254)));
    no_idle = 1'b1;
    test_random(250);
    no_idle = 1'b0;
    write_span(8'd1);
    test_random(250);
    drain();

    $display("%0d items sent, %0d dispatches found a task, %0d triggers refused",
             items_sent, dispatch_hits, refused_triggers);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
